[hw/rtl/u16c_pkg.sv]
// ----------------------------------------------------------------------------
// u16c_pkg: shared types and helpers for the UTF-16 command line splitter
// Code point slots, queue geometry, quote codes and UTF-8 encoding helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package u16c_pkg;

   localparam int UNIT_W  = 16;
   localparam int CP_W    = 21;
   localparam int NSLOT   = 3;
   localparam int QDEPTH  = 4;
   localparam int QAW     = $clog2(QDEPTH);
   localparam int QCW     = $clog2(QDEPTH + 1);

   // quote kind codes
   localparam logic [1:0] QK_NONE   = 2'd0;
   localparam logic [1:0] QK_DOUBLE = 2'd1;
   localparam logic [1:0] QK_SINGLE = 2'd2;

   localparam logic [UNIT_W-1:0] CH_DQUOTE = 16'h0022;
   localparam logic [UNIT_W-1:0] CH_SQUOTE = 16'h0027;
   localparam logic [UNIT_W-1:0] CH_BSLASH = 16'h005C;
   localparam logic [UNIT_W-1:0] CH_SPACE  = 16'h0020;
   localparam logic [UNIT_W-1:0] CH_TAB    = 16'h0009;
   localparam logic [UNIT_W-1:0] CH_CR     = 16'h000D;
   localparam logic [UNIT_W-1:0] CH_LF     = 16'h000A;

   localparam logic [CP_W-1:0] CP_BSLASH    = 21'h00005C;
   localparam logic [CP_W-1:0] CP_REPLACE   = 21'h00FFFD;
   localparam logic [CP_W-1:0] CP_SUPP_BASE = 21'h010000;

   // Slot 0: escape / surrogate leftover, slot 1: the unit itself,
   // slot 2: pending text flushed at argument close.
   typedef struct packed {
      logic [NSLOT-1:0][CP_W-1:0] cp;
      logic [NSLOT-1:0]           cp_valid;
      logic                       ended;
   } desc_type;

   function automatic logic is_blank(input logic [UNIT_W-1:0] u);
      is_blank = (u == CH_SPACE) || (u == CH_TAB) || (u == CH_CR) || (u == CH_LF);
   endfunction

   function automatic logic is_high(input logic [UNIT_W-1:0] u);
      is_high = (u[15:10] == 6'b110110);
   endfunction

   function automatic logic is_low(input logic [UNIT_W-1:0] u);
      is_low = (u[15:10] == 6'b110111);
   endfunction

   function automatic logic [UNIT_W-1:0] quote_char(input logic [1:0] qk);
      quote_char = (qk == QK_DOUBLE) ? CH_DQUOTE : CH_SQUOTE;
   endfunction

   // index of the last UTF-8 byte of a code point (length - 1)
   function automatic logic [1:0] utf8_last(input logic [CP_W-1:0] cp);
      if (cp <= 21'h00007F)      utf8_last = 2'd0;
      else if (cp <= 21'h0007FF) utf8_last = 2'd1;
      else if (cp <= 21'h00FFFF) utf8_last = 2'd2;
      else                       utf8_last = 2'd3;
   endfunction

   function automatic logic [7:0] utf8_byte(input logic [CP_W-1:0] cp,
                                            input logic [1:0]      idx);
      logic [1:0] last;
      last = utf8_last(cp);
      utf8_byte = 8'h00;
      unique case (last)
         2'd0: utf8_byte = cp[7:0];
         2'd1: utf8_byte = (idx == 2'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
         2'd2: begin
            unique case (idx)
               2'd0:    utf8_byte = {4'b1110, cp[15:12]};
               2'd1:    utf8_byte = {2'b10, cp[11:6]};
               default: utf8_byte = {2'b10, cp[5:0]};
            endcase
         end
         default: begin
            unique case (idx)
               2'd0:    utf8_byte = {5'b11110, cp[20:18]};
               2'd1:    utf8_byte = {2'b10, cp[17:12]};
               2'd2:    utf8_byte = {2'b10, cp[11:6]};
               default: utf8_byte = {2'b10, cp[5:0]};
            endcase
         end
      endcase
   endfunction

endpackage

`default_nettype wire

[hw/rtl/u16c_front.sv]
// ----------------------------------------------------------------------------
// u16c_front: unit classifier
// Tracks argument, quote, escape and surrogate state; turns each unit into
// up to three code points plus an argument-end flag.
// ----------------------------------------------------------------------------
`default_nettype none

module u16c_front
   import u16c_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept,
   input  wire logic [UNIT_W-1:0] unit,
   input  wire logic              eob,
   output desc_type               desc,
   output logic                   desc_push
);

   logic              in_ff,   in_in;
   logic [1:0]        qk_ff,   qk_in;
   logic              esc_ff,  esc_in;
   logic              hsp_ff,  hsp_in;
   logic [9:0]        hsb_ff,  hsb_in;
   logic              stop_ff, stop_in;
   logic              do_plain;
   logic              close_req;

   always_comb begin
      in_in     = in_ff;
      qk_in     = qk_ff;
      esc_in    = esc_ff;
      hsp_in    = hsp_ff;
      hsb_in    = hsb_ff;
      stop_in   = stop_ff;
      desc      = '0;
      do_plain  = 1'b0;
      close_req = 1'b0;

      if (!stop_ff) begin
         if (unit == '0) begin
            close_req = 1'b1;
            stop_in   = 1'b1;
         end else if (!in_ff) begin
            if (!is_blank(unit)) begin
               in_in = 1'b1;
               if (unit == CH_DQUOTE) begin
                  qk_in = QK_DOUBLE;
               end else if (unit == CH_SQUOTE) begin
                  qk_in = QK_SINGLE;
               end else begin
                  qk_in    = QK_NONE;
                  do_plain = 1'b1;
               end
            end
         end else begin
            do_plain = 1'b1;
            if (esc_ff) begin
               esc_in = 1'b0;
               desc.cp_valid[0] = 1'b1;
               if (qk_ff != QK_NONE && (unit == quote_char(qk_ff) || unit == CH_BSLASH)) begin
                  desc.cp[0] = {5'd0, unit};
                  do_plain   = 1'b0;
               end else begin
                  desc.cp[0] = CP_BSLASH;
               end
            end else if (hsp_ff) begin
               hsp_in = 1'b0;
               hsb_in = '0;
               desc.cp_valid[0] = 1'b1;
               if (is_low(unit)) begin
                  desc.cp[0] = CP_SUPP_BASE + {1'b0, hsb_ff, unit[9:0]};
                  do_plain   = 1'b0;
               end else begin
                  desc.cp[0] = CP_REPLACE;
               end
            end
         end
      end

      if (do_plain) begin
         if (qk_in != QK_NONE && unit == quote_char(qk_in)) begin
            close_req = 1'b1;
         end else if (qk_in != QK_NONE && unit == CH_BSLASH) begin
            esc_in = 1'b1;
         end else if (qk_in == QK_NONE && is_blank(unit)) begin
            close_req = 1'b1;
         end else if (is_high(unit)) begin
            hsp_in = 1'b1;
            hsb_in = unit[9:0];
         end else begin
            desc.cp_valid[1] = 1'b1;
            desc.cp[1]       = is_low(unit) ? CP_REPLACE : {5'd0, unit};
         end
      end

      // argument close flushes whatever is still pending
      if ((close_req || eob) && in_in) begin
         if (esc_in) begin
            desc.cp_valid[2] = 1'b1;
            desc.cp[2]       = CP_BSLASH;
         end else if (hsp_in) begin
            desc.cp_valid[2] = 1'b1;
            desc.cp[2]       = CP_REPLACE;
         end
         esc_in     = 1'b0;
         hsp_in     = 1'b0;
         hsb_in     = '0;
         in_in      = 1'b0;
         qk_in      = QK_NONE;
         desc.ended = 1'b1;
      end

      if (eob) begin
         in_in   = 1'b0;
         qk_in   = QK_NONE;
         esc_in  = 1'b0;
         hsp_in  = 1'b0;
         hsb_in  = '0;
         stop_in = 1'b0;
      end
   end

   assign desc_push = accept && ((|desc.cp_valid) || desc.ended);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_ff   <= 1'b0;
         qk_ff   <= QK_NONE;
         esc_ff  <= 1'b0;
         hsp_ff  <= 1'b0;
         hsb_ff  <= '0;
         stop_ff <= 1'b0;
      end else if (accept) begin
         in_ff   <= in_in;
         qk_ff   <= qk_in;
         esc_ff  <= esc_in;
         hsp_ff  <= hsp_in;
         hsb_ff  <= hsb_in;
         stop_ff <= stop_in;
      end
   end

`ifndef SYNTHESIS
   a_eob_clears: assert property (@(posedge clock) disable iff (reset)
      accept && eob |=> !in_ff && !stop_ff && !esc_ff && !hsp_ff)
      else $error("state not cleared after end of buffer");
   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      !in_ff |-> qk_ff == QK_NONE && !esc_ff && !hsp_ff)
      else $error("pending state outside an argument");
   a_one_pending: assert property (@(posedge clock) disable iff (reset)
      !(esc_ff && hsp_ff))
      else $error("escape and surrogate pending together");
   a_hsb_zero: assert property (@(posedge clock) disable iff (reset)
      !hsp_ff |-> hsb_ff == '0)
      else $error("stale surrogate bits");
`endif

endmodule

`default_nettype wire

[hw/rtl/u16c_queue.sv]
// ----------------------------------------------------------------------------
// u16c_queue: descriptor queue
// Small register FIFO between classifier and byte expander.
// ----------------------------------------------------------------------------
`default_nettype none

module u16c_queue
   import u16c_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  wire desc_type push_data,
   output logic          full,
   input  wire logic     pop,
   output desc_type      head,
   output logic          empty
);

   desc_type           mem_ff [QDEPTH];
   logic [QAW-1:0]     wptr_ff, wptr_in;
   logic [QAW-1:0]     rptr_ff, rptr_in;
   logic [QCW-1:0]     cnt_ff,  cnt_in;
   logic               do_push;
   logic               do_pop;

   assign full    = (cnt_ff == QCW'(QDEPTH));
   assign empty   = (cnt_ff == '0);
   assign head    = mem_ff[rptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wptr_in = do_push ? wptr_ff + 1'b1 : wptr_ff;
      rptr_in = do_pop  ? rptr_ff + 1'b1 : rptr_ff;
      cnt_in  = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/u16c_back.sv]
// ----------------------------------------------------------------------------
// u16c_back: byte expander
// Walks the head descriptor slot by slot and byte by byte, one result a pop.
// ----------------------------------------------------------------------------
`default_nettype none

module u16c_back
   import u16c_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire desc_type head,
   input  wire logic     q_empty,
   output logic          q_pop,
   input  wire logic     rsp_pop,
   output logic          rsp_empty,
   output logic [7:0]    rsp_out_byte,
   output logic          rsp_byte_valid,
   output logic          rsp_arg_end,
   output logic          rsp_run_last
);

   logic [1:0]      sidx_ff, sidx_in;
   logic [1:0]      bidx_ff, bidx_in;
   logic [NSLOT-1:0] live;
   logic [1:0]      cur;
   logic            have;
   logic            more;
   logic [CP_W-1:0] cur_cp;
   logic            slot_done;
   logic            last;
   logic            xfer;

   // slots at or after the walk position
   assign live[0] = head.cp_valid[0] && (sidx_ff == 2'd0);
   assign live[1] = head.cp_valid[1] && (sidx_ff <= 2'd1);
   assign live[2] = head.cp_valid[2] && (sidx_ff <= 2'd2);
   assign have    = |live;

   always_comb begin
      priority if (live[0]) begin
         cur  = 2'd0;
         more = head.cp_valid[1] || head.cp_valid[2];
      end else if (live[1]) begin
         cur  = 2'd1;
         more = head.cp_valid[2];
      end else begin
         cur  = 2'd2;
         more = 1'b0;
      end
   end

   assign cur_cp    = head.cp[cur];
   assign slot_done = (bidx_ff == utf8_last(cur_cp));
   assign last      = !have || (slot_done && !more);
   assign xfer      = rsp_pop && !q_empty;

   assign rsp_empty      = q_empty;
   assign rsp_byte_valid = have;
   assign rsp_out_byte   = have ? utf8_byte(cur_cp, bidx_ff) : 8'h00;
   assign rsp_arg_end    = last && head.ended;
   assign rsp_run_last   = last;
   assign q_pop          = xfer && last;

   always_comb begin
      sidx_in = sidx_ff;
      bidx_in = bidx_ff;
      if (xfer) begin
         if (last) begin
            sidx_in = 2'd0;
            bidx_in = 2'd0;
         end else if (slot_done) begin
            sidx_in = cur + 2'd1;
            bidx_in = 2'd0;
         end else begin
            bidx_in = bidx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sidx_ff <= 2'd0;
         bidx_ff <= 2'd0;
      end else begin
         sidx_ff <= sidx_in;
         bidx_ff <= bidx_in;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/utf16_cmdline_to_utf8_args.sv]
// Path: each accepted unit's descriptor is registered in the queue first.
// Throughput: one unit per cycle taken while the descriptor queue has room;
//   results leave one byte per cycle while the receiver pops; a unit with
//   k results takes k pops; a 4-entry queue absorbs bursts of long code points.
// Reset: synchronous, active high; clears splitter state and empties the queue.
// ----------------------------------------------------------------------------
// utf16_cmdline_to_utf8_args: UTF-16 command line to UTF-8 arguments
// Splits a UTF-16 unit stream at blanks, honors quotes and escapes, pairs
// surrogates and emits each argument as UTF-8 bytes with end markers.
// ----------------------------------------------------------------------------
`default_nettype none

module utf16_cmdline_to_utf8_args
   import u16c_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   // input transfer side
   input  wire logic              req_push,
   output logic                   req_full,
   input  wire logic [UNIT_W-1:0] req_code_unit,
   input  wire logic              req_end_of_buffer,
   // result transfer side
   output logic                   rsp_empty,
   input  wire logic              rsp_pop,
   output logic [7:0]             rsp_out_byte,
   output logic                   rsp_byte_valid,
   output logic                   rsp_arg_end,
   output logic                   rsp_run_last
);

   desc_type desc;
   desc_type head;
   logic     desc_push;
   logic     q_full;
   logic     q_empty;
   logic     q_pop;
   logic     accept;

   // The front takes a unit whenever the queue has room: its state update
   // does not wait on the back end at all.
   assign req_full = q_full;
   assign accept   = req_push && !q_full;

   u16c_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .unit      (req_code_unit),
      .eob       (req_end_of_buffer),
      .desc      (desc),
      .desc_push (desc_push)
   );

   // Units that cause no result (blanks between arguments, opening quotes, a high surrogate,
   // anything after a zero unit) never enter the queue.
   u16c_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (desc_push),
      .push_data (desc),
      .full      (q_full),
      .pop       (q_pop),
      .head      (head),
      .empty     (q_empty)
   );

   // The back end expands the head descriptor into byte transfers; the
   // descriptor leaves the queue with its last transfer.
   u16c_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .q_empty        (q_empty),
      .q_pop          (q_pop),
      .rsp_pop        (rsp_pop),
      .rsp_empty      (rsp_empty),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_byte_valid (rsp_byte_valid),
      .rsp_arg_end    (rsp_arg_end),
      .rsp_run_last   (rsp_run_last)
   );

`ifndef SYNTHESIS
   a_marker_shape: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_byte_valid |-> rsp_arg_end && rsp_run_last && rsp_out_byte == 8'h00)
      else $error("bare marker malformed");
   a_full_no_push: assert property (@(posedge clock) disable iff (reset)
      req_full |-> !desc_push || !accept)
      else $error("descriptor pushed into full queue");
   a_pop_on_last: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> rsp_run_last && rsp_pop && !rsp_empty)
      else $error("descriptor dropped before its last transfer");
`endif

endmodule

`default_nettype wire

[dv/tb_utf16_cmdline_to_utf8_args.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_utf16_cmdline_to_utf8_args: self-checking bench for the argument splitter
// Feeds UTF-16 command lines through the push/full side, predicts the UTF-8
// argument stream in-bench and checks every popped result field by field.
// ----------------------------------------------------------------------------

module tb_utf16_cmdline_to_utf8_args;
   import u16c_pkg::*;

   // a watchdog limit well above the longest legal quiet stretch
   // (receiver hold of HOLD_CYCLES plus long gaps on both sides)
   localparam int HOLD_CYCLES  = 300;
   localparam int QUIET_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 20;
   localparam int RANDOM_UNITS = 80;

   // one command-line unit as the sender offers it
   typedef struct {
      logic [UNIT_W-1:0] code;
      bit                eob;
   } cmd_unit_type;

   // one popped result: a UTF-8 byte or a bare end marker
   typedef struct packed {
      logic [7:0] data;
      logic       valid;
      logic       arg_end;
      logic       last;
   } utf8_result_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_push = 1'b0;
   logic              req_full;
   logic [UNIT_W-1:0] req_code_unit = '0;
   logic              req_end_of_buffer = 1'b0;
   logic              rsp_empty;
   logic              rsp_pop = 1'b0;
   logic [7:0]        rsp_out_byte;
   logic              rsp_byte_valid;
   logic              rsp_arg_end;
   logic              rsp_run_last;

   cmd_unit_type    line_units[$];      // units waiting to be offered
   utf8_result_type expected_bytes[$];  // predicted results, oldest first
   utf8_result_type step_bytes[$];      // results of the unit being predicted

   // splitter state mirrored by the predictor
   logic       split_in_arg;
   logic [1:0] split_quote;
   logic       split_esc;
   logic       split_hs;
   logic [9:0] split_hs_bits;
   logic       split_stopped;
   logic       split_ended;

   int  queued_units = 0;
   int  accepted_units = 0;
   int  live_units = 0;    // units that the splitter does not ignore
   bit  gen_dead = 0;      // generator is past a zero unit in this line
   int  results_seen = 0;
   int  args_closed = 0;
   int  mismatches = 0;
   int  quiet_cycles = 0;
   bit  no_idle = 0;       // both sides run flat out
   bit  rx_hold_req = 0;   // ask the receiver for one long hold-off

   utf16_cmdline_to_utf8_args i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_code_unit     (req_code_unit),
      .req_end_of_buffer (req_end_of_buffer),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_byte_valid    (rsp_byte_valid),
      .rsp_arg_end       (rsp_arg_end),
      .rsp_run_last      (rsp_run_last)
   );

   always #1 clock = ~clock;

   // ------------------------------------------------------------------------
   // Splitter prediction
   // ------------------------------------------------------------------------
   function automatic bit is_separator(input logic [UNIT_W-1:0] code);
      return code == CH_SPACE || code == CH_TAB || code == CH_CR || code == CH_LF;
   endfunction

   task automatic clear_splitter();
      split_in_arg  = 1'b0;
      split_quote   = QK_NONE;
      split_esc     = 1'b0;
      split_hs      = 1'b0;
      split_hs_bits = '0;
      split_stopped = 1'b0;
   endtask

   // results beyond eight per unit are dropped
   task automatic put_byte(input logic [7:0] b);
      utf8_result_type r;
      if (step_bytes.size() >= 8) return;
      r = '{data: b, valid: 1'b1, arg_end: 1'b0, last: 1'b0};
      step_bytes.push_back(r);
   endtask

   task automatic put_code_point(input logic [CP_W-1:0] cp);
      if (cp <= 21'h7F) begin
         put_byte(cp[7:0]);
      end else if (cp <= 21'h7FF) begin
         put_byte({3'b110, cp[10:6]});
         put_byte({2'b10, cp[5:0]});
      end else if (cp <= 21'hFFFF) begin
         put_byte({4'b1110, cp[15:12]});
         put_byte({2'b10, cp[11:6]});
         put_byte({2'b10, cp[5:0]});
      end else begin
         put_byte({5'b11110, cp[20:18]});
         put_byte({2'b10, cp[17:12]});
         put_byte({2'b10, cp[11:6]});
         put_byte({2'b10, cp[5:0]});
      end
   endtask

   // flush a dangling backslash or high surrogate, then close
   task automatic close_argument();
      if (!split_in_arg) return;
      if (split_esc) put_byte(8'h5C);
      if (split_hs) put_code_point(CP_REPLACE);
      split_esc     = 1'b0;
      split_hs      = 1'b0;
      split_hs_bits = '0;
      split_in_arg  = 1'b0;
      split_quote   = QK_NONE;
      split_ended   = 1'b1;
   endtask

   task automatic text_unit(input logic [UNIT_W-1:0] code);
      logic [UNIT_W-1:0] closer;
      closer = (split_quote == QK_DOUBLE) ? CH_DQUOTE : CH_SQUOTE;
      if (split_quote != QK_NONE) begin
         if (code == closer) begin
            close_argument();
            return;
         end
         if (code == CH_BSLASH) begin
            split_esc = 1'b1;
            return;
         end
      end else if (is_separator(code)) begin
         close_argument();
         return;
      end
      if (code[15:10] == 6'b110110) begin
         split_hs      = 1'b1;
         split_hs_bits = code[9:0];
      end else if (code[15:10] == 6'b110111) begin
         put_code_point(CP_REPLACE);
      end else begin
         put_code_point({5'd0, code});
      end
   endtask

   // a unit inside an argument: settle a pending escape or high half first
   task automatic arg_unit(input logic [UNIT_W-1:0] code);
      logic [UNIT_W-1:0] closer;
      closer = (split_quote == QK_DOUBLE) ? CH_DQUOTE : CH_SQUOTE;
      if (split_esc) begin
         split_esc = 1'b0;
         if (split_quote != QK_NONE && (code == closer || code == CH_BSLASH)) begin
            put_byte(code[7:0]);
            return;
         end
         put_byte(8'h5C);
      end else if (split_hs) begin
         split_hs = 1'b0;
         if (code[15:10] == 6'b110111) begin
            put_code_point(CP_SUPP_BASE + {1'b0, split_hs_bits, code[9:0]});
            split_hs_bits = '0;
            return;
         end
         split_hs_bits = '0;
         put_code_point(CP_REPLACE);
      end
      text_unit(code);
   endtask

   task automatic predict_unit(input logic [UNIT_W-1:0] code, input bit eob);
      int n;
      step_bytes.delete();
      split_ended = 1'b0;
      if (!split_stopped) begin
         if (code == '0) begin
            close_argument();
            split_stopped = 1'b1;
         end else if (!split_in_arg) begin
            if (!is_separator(code)) begin
               split_in_arg = 1'b1;
               if (code == CH_DQUOTE) split_quote = QK_DOUBLE;
               else if (code == CH_SQUOTE) split_quote = QK_SINGLE;
               else begin
                  split_quote = QK_NONE;
                  text_unit(code);
               end
            end
         end else begin
            arg_unit(code);
         end
      end
      if (eob) begin
         close_argument();
         clear_splitter();
      end
      // argument end rides on the last byte, or on a bare marker
      if (split_ended) begin
         if (step_bytes.size() > 0) step_bytes[step_bytes.size() - 1].arg_end = 1'b1;
         else step_bytes.push_back('{data: 8'h00, valid: 1'b0, arg_end: 1'b1, last: 1'b0});
      end
      n = step_bytes.size();
      if (n > 0) step_bytes[n - 1].last = 1'b1;
      foreach (step_bytes[i]) expected_bytes.push_back(step_bytes[i]);
   endtask

   // ------------------------------------------------------------------------
   // Stimulus generation
   // ------------------------------------------------------------------------
   task automatic queue_unit(input logic [UNIT_W-1:0] code, input bit eob);
      line_units.push_back('{code: code, eob: eob});
      queued_units++;
      if (!gen_dead) live_units++;
      if (code == '0) gen_dead = 1;
      if (eob) gen_dead = 0;
   endtask

   function automatic logic [UNIT_W-1:0] random_blank();
      case ($urandom_range(3))
         0:       return CH_SPACE;
         1:       return CH_TAB;
         2:       return CH_CR;
         default: return CH_LF;
      endcase
   endfunction

   // one unit from a weighted mix of every class the splitter tells apart
   function automatic logic [UNIT_W-1:0] random_piece();
      int r;
      r = $urandom_range(99);
      if (r < 40) return 16'($urandom_range(16'h21, 16'h7E));
      if (r < 47) return random_blank();
      if (r < 55) return $urandom_range(1) ? CH_DQUOTE : CH_SQUOTE;
      if (r < 63) return CH_BSLASH;
      if (r < 70) return 16'($urandom_range(16'h80, 16'h7FF));
      if (r < 77) begin
         if ($urandom_range(1)) return 16'($urandom_range(16'h800, 16'hD7FF));
         return 16'($urandom_range(16'hE000, 16'hFFFF));
      end
      if (r < 85) return 16'($urandom_range(16'hD800, 16'hDBFF));
      if (r < 91) return 16'($urandom_range(16'hDC00, 16'hDFFF));
      if (r < 99) return 16'($urandom_range(16'hFFFF));
      return 16'h0000;
   endfunction

   // word content: mostly single units, some surrogate pairs and escapes
   task automatic add_content();
      int r;
      r = $urandom_range(99);
      if (r < 20) begin
         queue_unit(16'($urandom_range(16'hD800, 16'hDBFF)), 0);
         queue_unit(16'($urandom_range(16'hDC00, 16'hDFFF)), 0);
      end else if (r < 35) begin
         queue_unit(CH_BSLASH, 0);
         case ($urandom_range(3))
            0:       queue_unit(CH_DQUOTE, 0);
            1:       queue_unit(CH_SQUOTE, 0);
            2:       queue_unit(CH_BSLASH, 0);
            default: queue_unit(16'($urandom_range(16'h21, 16'h7E)), 0);
         endcase
      end else begin
         queue_unit(random_piece(), 0);
      end
   endtask

   task automatic add_word();
      int kind;
      int n;
      logic [UNIT_W-1:0] quote;
      kind  = $urandom_range(2);
      quote = (kind == 1) ? CH_DQUOTE : CH_SQUOTE;
      n     = $urandom_range(0, 4);
      if (kind != 0) queue_unit(quote, 0);
      for (int i = 0; i < n; i++) add_content();
      // now and then leave the quote open
      if (kind != 0 && $urandom_range(9) != 0) queue_unit(quote, 0);
      if ($urandom_range(3) != 0) queue_unit(random_blank(), 0);
   endtask

   // a line is mostly well-formed words, sometimes plain noise; the last
   // unit always carries end_of_buffer
   task automatic add_line();
      int n;
      if ($urandom_range(9) < 2) begin
         n = $urandom_range(2, 8);
         for (int i = 0; i < n; i++) queue_unit(random_piece(), 0);
      end else begin
         n = $urandom_range(1, 3);
         for (int i = 0; i < n; i++) add_word();
      end
      queue_unit(random_piece(), 1);
   endtask

   function automatic int pick_gap();
      int r;
      if (no_idle) return 0;
      r = $urandom_range(99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // ------------------------------------------------------------------------
   // Driver: offers queued units, predicts each unit at its transfer
   // ------------------------------------------------------------------------
   int tx_gap = 0;

   always @(posedge clock) begin
      bit fire;
      fire = req_push && !req_full;
      if (reset) begin
         req_push <= 1'b0;
         tx_gap = 0;
      end else begin
         if (fire) begin
            predict_unit(req_code_unit, req_end_of_buffer);
            accepted_units++;
            tx_gap = pick_gap();
         end
         // a unit not yet taken stays on the port unchanged
         if (!req_push || fire) begin
            if (tx_gap > 0) begin
               tx_gap--;
               req_push <= 1'b0;
            end else if (line_units.size() > 0) begin
               req_push          <= 1'b1;
               req_code_unit     <= line_units[0].code;
               req_end_of_buffer <= line_units[0].eob;
               void'(line_units.pop_front());
            end else begin
               req_push <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: checks each popped result against the oldest prediction
   // ------------------------------------------------------------------------
   int rx_stall = 0;

   always @(posedge clock) begin
      utf8_result_type want;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            results_seen++;
            if (expected_bytes.size() == 0) begin
               $error("result with nothing expected: out_byte %02h", rsp_out_byte);
               mismatches++;
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_out_byte !== want.data) begin
                  $error("out_byte: expected %02h, got %02h", want.data, rsp_out_byte);
                  mismatches++;
               end
               if (rsp_byte_valid !== want.valid) begin
                  $error("byte_valid: expected %0b, got %0b", want.valid, rsp_byte_valid);
                  mismatches++;
               end
               if (rsp_arg_end !== want.arg_end) begin
                  $error("arg_end: expected %0b, got %0b", want.arg_end, rsp_arg_end);
                  mismatches++;
               end
               if (rsp_run_last !== want.last) begin
                  $error("run_last: expected %0b, got %0b", want.last, rsp_run_last);
                  mismatches++;
               end
               if (want.arg_end) args_closed++;
            end
         end
         // stall bookkeeping; a running stall comes first, then a requested long hold
         if (rx_stall > 0) begin
            rx_stall--;
            rsp_pop <= 1'b0;
         end else if (rx_hold_req) begin
            rx_hold_req = 0;
            rx_stall    = HOLD_CYCLES;
            rsp_pop     <= 1'b0;
         end else if (no_idle || $urandom_range(99) < 70) begin
            rsp_pop <= 1'b1;
         end else begin
            rx_stall = pick_gap();
            rsp_pop  <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Watchdog: too long without any transfer on either side
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: %0d units queued, %0d taken, %0d results pending",
                     queued_units, accepted_units, expected_bytes.size());
            $display("utf16_cmdline_to_utf8_args verification failed");
            $finish;
         end
      end
   end

   // everything offered has been taken and every prediction popped
   task automatic wait_drained();
      while (accepted_units != queued_units || expected_bytes.size() != 0)
         @(posedge clock);
   endtask

   // ------------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------------
   initial begin
      int target;
      clear_splitter();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: UTF-8 length boundaries and the 0xFFFF extreme, blank end
      queue_unit(16'h0041, 0); queue_unit(16'h007F, 0); queue_unit(16'h0080, 0);
      queue_unit(16'h07FF, 0); queue_unit(16'hFFFF, 0); queue_unit(CH_SPACE, 0);
      // surrogate pair, lone low, lone high closed by a tab
      queue_unit(16'hD83D, 0); queue_unit(16'hDE00, 0); queue_unit(16'hDC00, 0);
      queue_unit(16'hDBFF, 0); queue_unit(CH_TAB, 0);
      // double-quoted: escaped quote, escaped backslash, literal backslash
      queue_unit(CH_DQUOTE, 0); queue_unit(CH_BSLASH, 0); queue_unit(CH_DQUOTE, 0);
      queue_unit(CH_BSLASH, 0); queue_unit(CH_BSLASH, 0); queue_unit(CH_BSLASH, 0);
      queue_unit(16'h0078, 0); queue_unit(CH_DQUOTE, 0);
      // empty quoted pair, then a quote in mid-argument, closed by LF
      queue_unit(CH_SQUOTE, 0); queue_unit(CH_SQUOTE, 0);
      queue_unit(16'h0061, 0); queue_unit(CH_DQUOTE, 0); queue_unit(CH_LF, 0);
      // zero unit with a high half pending, an ignored unit ending the buffer
      queue_unit(16'hD800, 0); queue_unit(16'h0000, 0); queue_unit(16'h0042, 1);
      // unterminated single quote with a backslash pending at buffer end
      queue_unit(CH_SQUOTE, 0); queue_unit(CH_BSLASH, 1);
      wait_drained();

      // burst with a long receiver hold: the block must fill and push back
      target     = live_units;
      no_idle    = 1;
      rx_hold_req = 1;
      while (live_units < target + 45) add_line();
      wait_drained();

      // sender paused above until drained; now random traffic with idling
      no_idle = 0;
      while (live_units < target + RANDOM_UNITS) add_line();
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Ran %0d command-line units (%0d not ignored) through the splitter,",
               accepted_units, live_units);
      $display("checking %0d UTF-8 results that closed %0d arguments.",
               results_seen, args_closed);
      if (mismatches == 0) begin
         $display("utf16_cmdline_to_utf8_args verification clean");
      end else begin
         $display("utf16_cmdline_to_utf8_args verification failed");
      end
      $finish;
   end

endmodule
